// ===== design/ebcr_pkg.sv =====
package ebcr_pkg;

  // Default coordinate width of the canvas.
  localparam int COORD_BITS = 12;

  // Width of the configuration register index.
  localparam int CFG_ADDR_BITS = 3;

  // Width of the plot byte.
  localparam int VALUE_BITS = 8;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_BOX_LEFT   = 3'd0,
    REG_BOX_TOP    = 3'd1,
    REG_BOX_RIGHT  = 3'd2,
    REG_BOX_BOTTOM = 3'd3,
    REG_SHAPE_MODE = 3'd4,
    REG_PLOT_VALUE = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_FILL_BOX       = 2'd0,
    MODE_HOLLOW_BOX     = 2'd1,
    MODE_FILL_ELLIPSE   = 2'd2,
    MODE_HOLLOW_ELLIPSE = 2'd3
  } shape_mode_t;

  // Per-item control that rides beside the ellipse arithmetic.
  typedef struct packed {
    logic                  inbox;
    logic                  border;
    shape_mode_t           mode;
    logic [VALUE_BITS-1:0] value;
  } meta_t;

  // Ellipse membership of the cell itself and of its four neighbors.
  typedef struct packed {
    logic center;
    logic x_plus;
    logic x_minus;
    logic y_plus;
    logic y_minus;
  } ell_flags_t;

endpackage

// ===== design/ellipse_and_box_cell_rasterizer.sv =====
// Channel      Dir  Fields (lowest bits first)
// s_*          in   tdata: cell_x, cell_y
// m_*          out  tuser: plot; tdata: cell_value
// cfg_*        in   write enable, register index, write data
//
// One cell beat is taken every clock while the output is not stalled. The depth
// is set by the ellipse arithmetic: a cross product stage, a neighbor offset
// stage and a squaring stage sit between the input register and the output
// register. Reset is synchronous and clears the valid bits and configuration
// registers. When m_tready is low with a result waiting, the whole pipeline
// holds and s_tready drops in the same cycle.
module ellipse_and_box_cell_rasterizer #(
  parameter int COORD_BITS = ebcr_pkg::COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // cfg_data carries the widest register, a coordinate.
  input  logic                                cfg_we,
  input  logic [ebcr_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [COORD_BITS-1:0]               cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: cell_x, then cell_y, zero padded to whole bytes.
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: cell_value.
  output logic [ebcr_pkg::VALUE_BITS-1:0]     m_tdata,
  // m_tuser: plot.
  output logic                                m_tuser
);

  localparam int CB    = COORD_BITS;
  localparam int DEPTH = 4;

  // Configuration registers.
  logic [CB-1:0]                       box_left;
  logic [CB-1:0]                       box_top;
  logic [CB-1:0]                       box_right;
  logic [CB-1:0]                       box_bottom;
  ebcr_pkg::shape_mode_t               shape_mode;
  logic [ebcr_pkg::VALUE_BITS-1:0]     plot_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left   <= '0;
      box_top    <= '0;
      box_right  <= '0;
      box_bottom <= '0;
      shape_mode <= ebcr_pkg::MODE_FILL_BOX;
      plot_value <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ebcr_pkg::REG_BOX_LEFT:   box_left   <= cfg_data;
        ebcr_pkg::REG_BOX_TOP:    box_top    <= cfg_data;
        ebcr_pkg::REG_BOX_RIGHT:  box_right  <= cfg_data;
        ebcr_pkg::REG_BOX_BOTTOM: box_bottom <= cfg_data;
        ebcr_pkg::REG_SHAPE_MODE: shape_mode <= ebcr_pkg::shape_mode_t'(cfg_data[1:0]);
        ebcr_pkg::REG_PLOT_VALUE: plot_value <= cfg_data[ebcr_pkg::VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances whenever the output slot is free or drained.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage one: box tests and distances from the box center in doubled units.
  logic [CB-1:0] cell_x, cell_y;
  logic [CB:0]   sx, sy, tx, ty, dx_full, dy_full;
  logic          inbox_c, border_c;

  always_comb begin
    cell_x   = s_tdata[CB-1:0];
    cell_y   = s_tdata[2*CB-1:CB];
    sx       = {1'b0, box_left} + {1'b0, box_right};
    sy       = {1'b0, box_top} + {1'b0, box_bottom};
    tx       = {cell_x, 1'b0};
    ty       = {cell_y, 1'b0};
    dx_full  = (tx >= sx) ? (tx - sx) : (sx - tx);
    dy_full  = (ty >= sy) ? (ty - sy) : (sy - ty);
    inbox_c  = (cell_x >= box_left) && (cell_x <= box_right) &&
               (cell_y >= box_top) && (cell_y <= box_bottom);
    border_c = (cell_x == box_left) || (cell_x == box_right) ||
               (cell_y == box_top) || (cell_y == box_bottom);
  end

  // Inside the box the distance never exceeds the half-axis, so it fits CB bits.
  logic [CB-1:0]     s1_dx, s1_dy, s1_rx, s1_ry;
  logic              vld  [DEPTH];
  ebcr_pkg::meta_t   meta [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx         <= dx_full[CB-1:0];
      s1_dy         <= dy_full[CB-1:0];
      s1_rx         <= box_right - box_left;
      s1_ry         <= box_bottom - box_top;
      meta[0].inbox  <= inbox_c;
      meta[0].border <= border_c;
      meta[0].mode   <= shape_mode;
      meta[0].value  <= plot_value;
      for (int i = 1; i < DEPTH; i++) begin
        meta[i] <= meta[i-1];
      end
    end
  end

  // Stages two to four: cross products, neighbor offsets and squares.
  ebcr_pkg::ell_flags_t flags;

  ebcr_ellipse_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_ellipse (
    .clk   (clk),
    .en    (en),
    .dx    (s1_dx),
    .dy    (s1_dy),
    .rx    (s1_rx),
    .ry    (s1_ry),
    .flags (flags)
  );

  // Final stage: pick the shape test. A hollow ellipse keeps a cell inside the
  // ellipse that lies on the box border or has a row or column neighbor outside it.
  ebcr_pkg::meta_t m_last;
  logic            plot_c;

  always_comb begin
    m_last = meta[DEPTH-1];
    case (m_last.mode)
      ebcr_pkg::MODE_FILL_BOX:     plot_c = 1'b1;
      ebcr_pkg::MODE_HOLLOW_BOX:   plot_c = m_last.border;
      ebcr_pkg::MODE_FILL_ELLIPSE: plot_c = flags.center;
      ebcr_pkg::MODE_HOLLOW_ELLIPSE: begin
        plot_c = flags.center &&
                 (m_last.border || !flags.x_plus || !flags.x_minus ||
                  !flags.y_plus || !flags.y_minus);
      end
      default: plot_c = 1'b0;
    endcase
    plot_c = plot_c && m_last.inbox;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= plot_c;
      m_tdata <= plot_c ? m_last.value : '0;
    end
  end

`ifndef SYNTHESIS
  // A held result must block the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while a result is stalled");

  // An unplotted cell never carries a byte.
  a_no_plot_no_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("unplotted result carries a nonzero byte");

  // A cell inside the box lies within the half-axes of the ellipse frame.
  a_inbox_distance: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && meta[0].inbox) |-> ((s1_dx <= s1_rx) && (s1_dy <= s1_ry)))
    else $error("in-box cell distance exceeds box extent");

  // An accepted beat reaches the first stage on the next edge.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted beat lost at the first stage");
`endif

endmodule

// ===== design/ebcr_ellipse_pipe.sv =====
// Three register stages of ellipse arithmetic on doubled-coordinate distances,
// followed by the sum-and-compare that yields the membership flags.
module ebcr_ellipse_pipe #(
  parameter int COORD_BITS = ebcr_pkg::COORD_BITS
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [COORD_BITS-1:0]  dx,
  input  logic [COORD_BITS-1:0]  dy,
  input  logic [COORD_BITS-1:0]  rx,
  input  logic [COORD_BITS-1:0]  ry,
  output ebcr_pkg::ell_flags_t   flags
);

  localparam int PW = 2 * COORD_BITS;
  localparam int NW = PW + 1;
  localparam int SW = 2 * NW;
  localparam int TW = SW + 1;

  // Stage two: cross products.
  logic [PW-1:0]         p;
  logic [PW-1:0]         q;
  logic [PW-1:0]         r;
  logic [COORD_BITS:0]   ry2;
  logic [COORD_BITS:0]   rx2;

  // Stage three: magnitudes for the cell and its neighbors.
  logic [NW-1:0] pc, pp, pm;
  logic [NW-1:0] qc, qp, qm;
  logic [NW-1:0] rc;

  // Stage four: squares.
  logic [SW-1:0] a, ap, am;
  logic [SW-1:0] b, bp, bm;
  logic [SW-1:0] c;

  always_ff @(posedge clk) begin
    if (en) begin
      p   <= PW'(dx) * PW'(ry);
      q   <= PW'(dy) * PW'(rx);
      r   <= PW'(rx) * PW'(ry);
      ry2 <= {ry, 1'b0};
      rx2 <= {rx, 1'b0};

      // A neighbor one column away has distance dx + 2 or |dx - 2|.
      pc <= NW'(p);
      pp <= NW'(p) + NW'(ry2);
      pm <= (p >= PW'(ry2)) ? NW'(p - PW'(ry2)) : NW'(PW'(ry2) - p);
      qc <= NW'(q);
      qp <= NW'(q) + NW'(rx2);
      qm <= (q >= PW'(rx2)) ? NW'(q - PW'(rx2)) : NW'(PW'(rx2) - q);
      rc <= NW'(r);

      a  <= SW'(pc) * SW'(pc);
      ap <= SW'(pp) * SW'(pp);
      am <= SW'(pm) * SW'(pm);
      b  <= SW'(qc) * SW'(qc);
      bp <= SW'(qp) * SW'(qp);
      bm <= SW'(qm) * SW'(qm);
      c  <= SW'(rc) * SW'(rc);
    end
  end

  always_comb begin
    flags.center  = (TW'(a)  + TW'(b))  <= TW'(c);
    flags.x_plus  = (TW'(ap) + TW'(b))  <= TW'(c);
    flags.x_minus = (TW'(am) + TW'(b))  <= TW'(c);
    flags.y_plus  = (TW'(a)  + TW'(bp)) <= TW'(c);
    flags.y_minus = (TW'(a)  + TW'(bm)) <= TW'(c);
  end

endmodule
